// ===== design/lsac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice site access package
// Shared widths, codes, structures and the stride helper used by the
// lattice site access block.
// ----------------------------------------------------------------------------
package lsac_pkg;

    // Sizes of the lattice store and the fixed field widths.
    localparam int NUM_COORDS  = 4;
    localparam int MAX_DIMS    = 4;
    localparam int DIM_LIMIT   = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;
    localparam int CAPACITY    = 4096;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CAP_W       = $clog2(CAPACITY + 1);
    localparam int LEN_W       = 13;
    localparam int DATA_W      = 16;
    localparam int MAG_W       = DATA_W - 1;
    localparam int FUNC_W      = 2;
    localparam int CLASS_W     = 2;
    localparam int NDIM_W      = 3;
    localparam int PROD_W      = LEN_W + CAP_W;
    localparam int SUM_W       = PROD_W + $clog2(NUM_COORDS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 3;
    localparam int SETTLE_W    = 2;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Site classes.
    localparam logic [CLASS_W-1:0] CLASS_NORMAL  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_CLOSED  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_OPEN    = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_OUTSIDE = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEN_DIM0   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEN_DIM1   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEN_DIM2   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEN_DIM3   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OPEN_EDGES = 3'd5;

    // Lattice geometry as seen by the front end.
    typedef struct packed {
        logic [NUM_COORDS-1:0]                  dim_used;
        logic [NUM_COORDS-1:0][LEN_W-1:0]       len;
        logic [NUM_COORDS-1:0][CAP_W-1:0]       stride;
        logic [2*NUM_COORDS-1:0]                open_edges;
    } lsac_cfg_t;

    // One classified request waiting for the store.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  diff;
        logic [CLASS_W-1:0] site_class;
        logic               outside;
    } lsac_entry_t;

    // Next stride, saturated at the capacity: any stride at or above the
    // capacity already pushes a nonzero coordinate past the store.
    function automatic logic [CAP_W-1:0] cap_mul(input logic [CAP_W-1:0] stride,
                                                 input logic [LEN_W-1:0] len);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(stride) * PROD_W'(len);
        if (prod >= PROD_W'(CAPACITY)) begin
            cap_mul = CAP_W'(CAPACITY);
        end else begin
            cap_mul = prod[CAP_W-1:0];
        end
    endfunction

endpackage

// ===== design/lattice_site_access_with_boundary_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice site access with boundary class
// Lattice of signed 16-bit heights of up to four dimensions. Each request
// reads, adds to or clears one site named by its coordinates and returns
// the value together with the boundary class of the site.
//
//   Channel  Direction  Handshake           Word
//   s_       in         s_valid / s_ready   func, coord_0..3, diff
//   m_       out        m_valid / m_ready   value, site_class
//   config   in/out     APB, pready high    six registers at 4*index
//
// One request per cycle is sustained while m_ready stays high and s_ready
// is not held low. An accepted request passes front stage one, front stage
// two, the queue write, the store read and execute into the output
// register before m_valid rises. Reset runs a clearing pass over the store,
// one entry per cycle, with s_ready low. After each register write s_ready
// stays low while the strides settle. A stalled output fills the queue,
// then the front end stops accepting.
// ----------------------------------------------------------------------------
module lattice_site_access_with_boundary_class (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsac_pkg::PADDR_W-1:0]        paddr,
    input  logic [lsac_pkg::PDATA_W-1:0]        pwdata,
    output logic [lsac_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lsac_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [lsac_pkg::DATA_W-1:0]  s_coord_0,
    input  logic signed [lsac_pkg::DATA_W-1:0]  s_coord_1,
    input  logic signed [lsac_pkg::DATA_W-1:0]  s_coord_2,
    input  logic signed [lsac_pkg::DATA_W-1:0]  s_coord_3,
    input  logic signed [lsac_pkg::DATA_W-1:0]  s_diff,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lsac_pkg::DATA_W-1:0]  m_value,
    output logic [lsac_pkg::CLASS_W-1:0]        m_site_class
);

    logic [lsac_pkg::NDIM_W-1:0]                              num_dims_reg;
    logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::LEN_W-1:0]     len_reg;
    logic [2*lsac_pkg::NUM_COORDS-1:0]                        open_edges_reg;
    logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::CAP_W-1:0]     stride_reg;
    logic [lsac_pkg::SETTLE_W-1:0]                            settle_reg;

    logic [lsac_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;
    logic [lsac_pkg::NDIM_W-1:0]    used_n;
    lsac_pkg::lsac_cfg_t            cfg;
    logic                           accept_en;
    logic                           clear_done;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    logic                           q_empty;
    lsac_pkg::lsac_entry_t          q_in;
    lsac_pkg::lsac_entry_t          q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lsac_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg   <= lsac_pkg::NDIM_W'(2);
            len_reg        <= {lsac_pkg::NUM_COORDS{lsac_pkg::LEN_W'(1)}};
            open_edges_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                lsac_pkg::REG_NUM_DIMS:   num_dims_reg   <= pwdata[lsac_pkg::NDIM_W-1:0];
                lsac_pkg::REG_LEN_DIM0:   len_reg[0]     <= pwdata[lsac_pkg::LEN_W-1:0];
                lsac_pkg::REG_LEN_DIM1:   len_reg[1]     <= pwdata[lsac_pkg::LEN_W-1:0];
                lsac_pkg::REG_LEN_DIM2:   len_reg[2]     <= pwdata[lsac_pkg::LEN_W-1:0];
                lsac_pkg::REG_LEN_DIM3:   len_reg[3]     <= pwdata[lsac_pkg::LEN_W-1:0];
                lsac_pkg::REG_OPEN_EDGES: open_edges_reg <= pwdata[2*lsac_pkg::NUM_COORDS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            lsac_pkg::REG_NUM_DIMS:   prdata = lsac_pkg::PDATA_W'(num_dims_reg);
            lsac_pkg::REG_LEN_DIM0:   prdata = lsac_pkg::PDATA_W'(len_reg[0]);
            lsac_pkg::REG_LEN_DIM1:   prdata = lsac_pkg::PDATA_W'(len_reg[1]);
            lsac_pkg::REG_LEN_DIM2:   prdata = lsac_pkg::PDATA_W'(len_reg[2]);
            lsac_pkg::REG_LEN_DIM3:   prdata = lsac_pkg::PDATA_W'(len_reg[3]);
            lsac_pkg::REG_OPEN_EDGES: prdata = lsac_pkg::PDATA_W'(open_edges_reg);
            default:                  prdata = '0;
        endcase
    end

    // Strides, one multiply per stage, saturated at the store capacity.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= {lsac_pkg::NUM_COORDS{lsac_pkg::CAP_W'(1)}};
        end else begin
            stride_reg[0] <= lsac_pkg::CAP_W'(1);
            for (int d = 1; d < lsac_pkg::NUM_COORDS; d++) begin
                stride_reg[d] <= lsac_pkg::cap_mul(stride_reg[d-1], len_reg[d-1]);
            end
        end
    end

    // Hold off requests until the stride chain has settled after a write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= '0;
        end else if (cfg_wr) begin
            settle_reg <= '1;
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    // Dimensions in use: zero counts as one, too many as the limit.
    always_comb begin
        if (num_dims_reg == '0) begin
            used_n = lsac_pkg::NDIM_W'(1);
        end else if (num_dims_reg > lsac_pkg::NDIM_W'(lsac_pkg::DIM_LIMIT)) begin
            used_n = lsac_pkg::NDIM_W'(lsac_pkg::DIM_LIMIT);
        end else begin
            used_n = num_dims_reg;
        end
        for (int d = 0; d < lsac_pkg::NUM_COORDS; d++) begin
            cfg.dim_used[d] = (lsac_pkg::NDIM_W'(d) < used_n);
        end
        cfg.len        = len_reg;
        cfg.stride     = stride_reg;
        cfg.open_edges = open_edges_reg;
    end

    assign accept_en = clear_done && (settle_reg == '0);

    lsac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept_en (accept_en),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_coord_0 (s_coord_0),
        .s_coord_1 (s_coord_1),
        .s_coord_2 (s_coord_2),
        .s_coord_3 (s_coord_3),
        .s_diff    (s_diff),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    lsac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    lsac_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .clear_done   (clear_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_site_class (m_site_class)
    );

endmodule

// ===== design/lsac_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request queue
// Short first-in first-out buffer between the classifying front end and the
// store back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module lsac_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lsac_pkg::lsac_entry_t push_data,
    output logic                 full,
    input  logic                 pop,
    output lsac_pkg::lsac_entry_t pop_data,
    output logic                 empty
);

    lsac_pkg::lsac_entry_t                entries [lsac_pkg::QUEUE_DEPTH];
    logic [lsac_pkg::QPTR_W-1:0]          wr_ptr_reg;
    logic [lsac_pkg::QPTR_W-1:0]          rd_ptr_reg;
    logic [lsac_pkg::QCNT_W-1:0]          count_reg;
    logic                                 do_push;
    logic                                 do_pop;

    assign full     = (count_reg == lsac_pkg::QCNT_W'(lsac_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == lsac_pkg::QPTR_W'(lsac_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == lsac_pkg::QPTR_W'(lsac_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/lsac_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, checks each coordinate against its length, classifies
// the site and forms the linear address from the strides.
// ----------------------------------------------------------------------------
module lsac_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept_en,
    input  lsac_pkg::lsac_cfg_t                  cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lsac_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [lsac_pkg::DATA_W-1:0]   s_coord_0,
    input  logic signed [lsac_pkg::DATA_W-1:0]   s_coord_1,
    input  logic signed [lsac_pkg::DATA_W-1:0]   s_coord_2,
    input  logic signed [lsac_pkg::DATA_W-1:0]   s_coord_3,
    input  logic signed [lsac_pkg::DATA_W-1:0]   s_diff,
    input  logic                                 q_full,
    output logic                                 q_push,
    output lsac_pkg::lsac_entry_t                q_data
);

    // Stage one: the accepted word.
    logic                                          f1_valid_reg;
    logic [lsac_pkg::FUNC_W-1:0]                   f1_func_reg;
    logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::DATA_W-1:0] f1_coord_reg;
    logic [lsac_pkg::DATA_W-1:0]                   f1_diff_reg;

    // Stage two: per-dimension products and flags.
    logic                                          f2_valid_reg;
    logic [lsac_pkg::FUNC_W-1:0]                   f2_func_reg;
    logic [lsac_pkg::DATA_W-1:0]                   f2_diff_reg;
    logic                                          f2_out_reg;
    logic [lsac_pkg::CLASS_W-1:0]                  f2_class_reg;
    logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::PROD_W-1:0] f2_prod_reg;

    logic                                          front_go;
    logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::DATA_W-1:0] in_coord;
    logic [lsac_pkg::NUM_COORDS-1:0]               dim_out;
    logic [lsac_pkg::NUM_COORDS-1:0]               dim_open;
    logic [lsac_pkg::NUM_COORDS-1:0]               dim_edge;
    logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::PROD_W-1:0] dim_prod;
    logic [lsac_pkg::CLASS_W-1:0]                  class_next;
    logic [lsac_pkg::SUM_W-1:0]                    addr_sum;
    logic                                          outside;

    assign in_coord[0] = s_coord_0;
    assign in_coord[1] = s_coord_1;
    assign in_coord[2] = s_coord_2;
    assign in_coord[3] = s_coord_3;

    // The whole front moves together whenever its last stage can drain.
    assign front_go = !f2_valid_reg || !q_full;
    assign s_ready  = front_go && accept_en;

    // Per-dimension range check, edge detection and address term.
    always_comb begin
        logic [lsac_pkg::MAG_W-1:0] cmag;
        logic [lsac_pkg::MAG_W-1:0] len_ext;
        logic                       in_range;
        logic                       lower;
        logic                       upper;
        for (int d = 0; d < lsac_pkg::NUM_COORDS; d++) begin
            cmag     = f1_coord_reg[d][lsac_pkg::MAG_W-1:0];
            len_ext  = lsac_pkg::MAG_W'(cfg.len[d]);
            in_range = !f1_coord_reg[d][lsac_pkg::DATA_W-1] && (cmag < len_ext);
            lower    = (f1_coord_reg[d] == '0);
            upper    = !lower && (cmag == len_ext - 1'b1);
            dim_out[d]  = cfg.dim_used[d] && !in_range;
            dim_open[d] = cfg.dim_used[d] &&
                          ((lower && cfg.open_edges[2*d]) || (upper && cfg.open_edges[2*d+1]));
            dim_edge[d] = cfg.dim_used[d] && (lower || upper);
            if (cfg.dim_used[d] && in_range) begin
                dim_prod[d] = lsac_pkg::PROD_W'(cmag[lsac_pkg::LEN_W-1:0]) *
                              lsac_pkg::PROD_W'(cfg.stride[d]);
            end else begin
                dim_prod[d] = '0;
            end
        end
        if (|dim_open) begin
            class_next = lsac_pkg::CLASS_OPEN;
        end else if (|dim_edge) begin
            class_next = lsac_pkg::CLASS_CLOSED;
        end else begin
            class_next = lsac_pkg::CLASS_NORMAL;
        end
    end

    // Front pipeline registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (front_go) begin
            f1_valid_reg <= s_valid && accept_en;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (front_go) begin
            f1_func_reg  <= s_func;
            f1_coord_reg <= in_coord;
            f1_diff_reg  <= s_diff;
            f2_func_reg  <= f1_func_reg;
            f2_diff_reg  <= f1_diff_reg;
            f2_out_reg   <= |dim_out;
            f2_class_reg <= class_next;
            f2_prod_reg  <= dim_prod;
        end
    end

    // Address sum and capacity check on the way into the queue.
    always_comb begin
        addr_sum = '0;
        for (int d = 0; d < lsac_pkg::NUM_COORDS; d++) begin
            addr_sum = addr_sum + lsac_pkg::SUM_W'(f2_prod_reg[d]);
        end
        outside = f2_out_reg || (addr_sum >= lsac_pkg::SUM_W'(lsac_pkg::CAPACITY));
    end

    assign q_push            = f2_valid_reg && !q_full;
    assign q_data.func       = f2_func_reg;
    assign q_data.addr       = addr_sum[lsac_pkg::ADDR_W-1:0];
    assign q_data.diff       = f2_diff_reg;
    assign q_data.site_class = outside ? lsac_pkg::CLASS_OUTSIDE : f2_class_reg;
    assign q_data.outside    = outside;

endmodule

// ===== design/lsac_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Store back end
// Holds the height store, clears it after reset, and performs the read,
// add or clear of each queued request with forwarding of the last write.
// ----------------------------------------------------------------------------
module lsac_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  lsac_pkg::lsac_entry_t               q_data,
    output logic                                q_pop,
    output logic                                clear_done,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lsac_pkg::DATA_W-1:0]  m_value,
    output logic [lsac_pkg::CLASS_W-1:0]        m_site_class
);

    logic [lsac_pkg::DATA_W-1:0] heights_mem [lsac_pkg::CAPACITY];

    logic                         clear_done_reg;
    logic [lsac_pkg::ADDR_W-1:0]  clr_addr_reg;

    logic                         w_valid_reg;
    lsac_pkg::lsac_entry_t        w_entry_reg;
    logic [lsac_pkg::DATA_W-1:0]  rdata_reg;

    logic                         fwd_valid_reg;
    logic [lsac_pkg::ADDR_W-1:0]  fwd_addr_reg;
    logic [lsac_pkg::DATA_W-1:0]  fwd_data_reg;

    logic                         m_valid_reg;
    logic [lsac_pkg::DATA_W-1:0]  m_value_reg;
    logic [lsac_pkg::CLASS_W-1:0] m_class_reg;

    logic                         w_go;
    logic [lsac_pkg::DATA_W-1:0]  old_val;
    logic [lsac_pkg::DATA_W-1:0]  new_val;
    logic [lsac_pkg::DATA_W-1:0]  res_val;
    logic                         item_we;
    logic                         mem_we;
    logic [lsac_pkg::ADDR_W-1:0]  mem_waddr;
    logic [lsac_pkg::DATA_W-1:0]  mem_wdata;

    // Handshake between the queue, the execute stage and the output word.
    assign w_go  = w_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop = !q_empty && clear_done_reg && (!w_valid_reg || w_go);

    // The latest write wins over the memory data read when the request was popped.
    assign old_val = (fwd_valid_reg && (fwd_addr_reg == w_entry_reg.addr))
                     ? fwd_data_reg : rdata_reg;

    // Execute the request.
    always_comb begin
        new_val = old_val;
        res_val = old_val;
        item_we = 1'b0;
        case (w_entry_reg.func)
            lsac_pkg::FUNC_ADD: begin
                new_val = old_val + w_entry_reg.diff;
                res_val = new_val;
                item_we = 1'b1;
            end
            lsac_pkg::FUNC_CLEAR: begin
                new_val = '0;
                item_we = 1'b1;
            end
            default: begin
                item_we = 1'b0;
            end
        endcase
        if (w_entry_reg.outside) begin
            res_val = '0;
            item_we = 1'b0;
        end
        item_we = item_we && w_go;
    end

    // Write port is shared with the clearing pass.
    assign mem_we    = !clear_done_reg || item_we;
    assign mem_waddr = clear_done_reg ? w_entry_reg.addr : clr_addr_reg;
    assign mem_wdata = clear_done_reg ? new_val : '0;

    // Height store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heights_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rdata_reg <= heights_mem[q_data.addr];
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_done_reg <= 1'b0;
            clr_addr_reg   <= '0;
        end else if (!clear_done_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == lsac_pkg::ADDR_W'(lsac_pkg::CAPACITY - 1)) begin
                clear_done_reg <= 1'b1;
            end
        end
    end

    // Execute stage and forwarding register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                w_valid_reg <= 1'b1;
            end else if (w_go) begin
                w_valid_reg <= 1'b0;
            end
            if (item_we) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            w_entry_reg <= q_data;
        end
        if (item_we) begin
            fwd_addr_reg <= w_entry_reg.addr;
            fwd_data_reg <= new_val;
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (w_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (w_go) begin
            m_value_reg <= res_val;
            m_class_reg <= w_entry_reg.site_class;
        end
    end

    assign clear_done   = clear_done_reg;
    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_site_class = m_class_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice site access testbench
// Sends site requests through the input channel and checks every returned
// word against an in-bench prediction. The prediction keeps its own height
// store and register copy. The run starts with a directed set of corner
// cases. It then steps through a series of lattice geometries with random
// requests, with idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    // Request word and result word as the bench sees them.
    typedef struct packed {
        logic [lsac_pkg::FUNC_W-1:0]                              func;
        logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::DATA_W-1:0]    coord;
        logic [lsac_pkg::DATA_W-1:0]                              diff;
    } site_req_t;

    typedef struct packed {
        logic [lsac_pkg::DATA_W-1:0]  value;
        logic [lsac_pkg::CLASS_W-1:0] site_class;
    } site_resp_t;

    typedef logic [lsac_pkg::NUM_COORDS-1:0][lsac_pkg::DATA_W-1:0] site_coords_t;

    // The one function code the block does not define; it must act as a read.
    localparam logic [lsac_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_WORDS   = 190;
    localparam int RESET_CYCLES  = 11;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [lsac_pkg::PADDR_W-1:0]         paddr = '0;
    logic [lsac_pkg::PDATA_W-1:0]         pwdata = '0;
    logic [lsac_pkg::PDATA_W-1:0]         prdata;
    logic                                 pready;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [lsac_pkg::FUNC_W-1:0]          s_func = '0;
    logic signed [lsac_pkg::DATA_W-1:0]   s_coord_0 = '0;
    logic signed [lsac_pkg::DATA_W-1:0]   s_coord_1 = '0;
    logic signed [lsac_pkg::DATA_W-1:0]   s_coord_2 = '0;
    logic signed [lsac_pkg::DATA_W-1:0]   s_coord_3 = '0;
    logic signed [lsac_pkg::DATA_W-1:0]   s_diff = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [lsac_pkg::DATA_W-1:0]   m_value;
    logic [lsac_pkg::CLASS_W-1:0]         m_site_class;

    // Register copy and height store used by the prediction.
    logic [lsac_pkg::NDIM_W-1:0]          cfg_num_dims = 3'd2;
    logic [lsac_pkg::LEN_W-1:0]           cfg_len [lsac_pkg::NUM_COORDS] = '{default: 13'd1};
    logic [2*lsac_pkg::NUM_COORDS-1:0]    cfg_open = '0;
    logic [lsac_pkg::DATA_W-1:0]          heights_model [lsac_pkg::CAPACITY] = '{default: '0};

    site_req_t                  pending_words [$];
    site_resp_t                 expected_results [$];
    site_coords_t               recent_sites [$];
    int                         words_queued = 0;
    int                         words_accepted = 0;
    int                         mismatch_count = 0;
    bit                         word_taken = 1'b0;
    int                         tx_idle_pct = 11;
    int                         rx_idle_pct = 65;
    int                         hold_requests = 0;
    int                         hold_served = 0;
    int                         hold_left = 0;

    lattice_site_access_with_boundary_class dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_coord_0    (s_coord_0),
        .s_coord_1    (s_coord_1),
        .s_coord_2    (s_coord_2),
        .s_coord_3    (s_coord_3),
        .s_diff       (s_diff),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_site_class (m_site_class)
    );

    always #2 aclk = ~aclk;

    // Classify the site, apply the request to the height store and return
    // the word the block should produce.
    function automatic site_resp_t apply_site_request(input site_req_t w);
        int         n;
        int         d;
        int         c;
        int         len;
        longint     addr;
        longint     stride;
        bit         outside;
        logic [lsac_pkg::CLASS_W-1:0] cls;
        logic [lsac_pkg::DATA_W-1:0]  old;
        site_resp_t r;
        n = int'(cfg_num_dims);
        if (n < 1) n = 1;
        if (n > lsac_pkg::DIM_LIMIT) n = lsac_pkg::DIM_LIMIT;
        addr = 0;
        stride = 1;
        outside = 1'b0;
        cls = lsac_pkg::CLASS_NORMAL;
        for (d = 0; d < n && !outside; d++) begin
            c = $signed(w.coord[d]);
            len = int'(cfg_len[d]);
            if (c < 0 || c >= len) begin
                outside = 1'b1;
            end else begin
                // A site at coordinate zero only sees the lower edge.
                if (c == 0) begin
                    if (cfg_open[2*d]) cls = lsac_pkg::CLASS_OPEN;
                    else if (cls != lsac_pkg::CLASS_OPEN) cls = lsac_pkg::CLASS_CLOSED;
                end else if (c == len - 1) begin
                    if (cfg_open[2*d+1]) cls = lsac_pkg::CLASS_OPEN;
                    else if (cls != lsac_pkg::CLASS_OPEN) cls = lsac_pkg::CLASS_CLOSED;
                end
                addr += longint'(c) * stride;
                stride *= len;
            end
        end
        if (!outside && addr >= lsac_pkg::CAPACITY) outside = 1'b1;
        if (outside) begin
            r.value = '0;
            r.site_class = lsac_pkg::CLASS_OUTSIDE;
            return r;
        end
        old = heights_model[addr];
        r.site_class = cls;
        case (w.func)
            lsac_pkg::FUNC_ADD: begin
                r.value = old + w.diff;
                heights_model[addr] = r.value;
            end
            lsac_pkg::FUNC_CLEAR: begin
                r.value = old;
                heights_model[addr] = '0;
            end
            default: begin
                r.value = old;
            end
        endcase
        return r;
    endfunction

    // Coordinate along a dimension of the given length: mostly inside, with
    // weight on the edges, some just outside and some anywhere in 16 bits.
    function automatic int pick_coord(input int len);
        int r;
        r = $urandom_range(99);
        if (r < 5) return $urandom_range(65535);
        if (r < 10) return ($urandom_range(1) != 0) ? -1 : len;
        if (len == 0) return $urandom_range(3);
        if (r < 30) return ($urandom_range(1) != 0) ? 0 : len - 1;
        return $urandom_range(len - 1);
    endfunction

    // Input driver: a new word is presented only once the last one is taken.
    always @(negedge aclk) begin : drive_words
        site_req_t w;
        if (!s_valid || word_taken) begin
            if (aresetn && pending_words.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                w = pending_words.pop_front();
                s_valid <= 1'b1;
                s_func <= w.func;
                s_coord_0 <= w.coord[0];
                s_coord_1 <= w.coord[1];
                s_coord_2 <= w.coord[2];
                s_coord_3 <= w.coord[3];
                s_diff <= w.diff;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predict each accepted request, check each accepted result.
    always @(posedge aclk) begin : watch_channels
        site_req_t  w;
        site_resp_t exp_word;
        word_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                w.func = s_func;
                w.coord[0] = s_coord_0;
                w.coord[1] = s_coord_1;
                w.coord[2] = s_coord_2;
                w.coord[3] = s_coord_3;
                w.diff = s_diff;
                expected_results.insert(expected_results.size(), apply_site_request(w));
                words_accepted++;
                word_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with none expected: value %0d class %0d",
                             $time, m_value, m_site_class);
                    mismatch_count++;
                end else begin
                    exp_word = expected_results.pop_front();
                    if (m_value !== exp_word.value) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, $signed(exp_word.value), m_value);
                        mismatch_count++;
                    end
                    if (m_site_class !== exp_word.site_class) begin
                        $display("%0t: site_class mismatch: expected %0d, actual %0d",
                                 $time, exp_word.site_class, m_site_class);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Queue one request word for the driver.
    task automatic queue_word(input logic [lsac_pkg::FUNC_W-1:0] func, input int c0,
                              input int c1, input int c2, input int c3, input int diff);
        site_req_t w;
        w.func = func;
        w.coord[0] = lsac_pkg::DATA_W'(c0);
        w.coord[1] = lsac_pkg::DATA_W'(c1);
        w.coord[2] = lsac_pkg::DATA_W'(c2);
        w.coord[3] = lsac_pkg::DATA_W'(c3);
        w.diff = lsac_pkg::DATA_W'(diff);
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    // Random requests; about a third go back to a recently used site so that
    // adds pile up and hit the same entry back to back.
    task automatic queue_random_words(input int count);
        site_req_t    w;
        site_coords_t site;
        int           k;
        int           d;
        int           r;
        for (k = 0; k < count; k++) begin
            if (recent_sites.size() != 0 && $urandom_range(99) < 30) begin
                site = recent_sites[$urandom_range(recent_sites.size() - 1)];
            end else begin
                for (d = 0; d < lsac_pkg::NUM_COORDS; d++) begin
                    site[d] = lsac_pkg::DATA_W'(pick_coord(int'(cfg_len[d])));
                end
                recent_sites.insert(recent_sites.size(), site);
                if (recent_sites.size() > 8) void'(recent_sites.pop_front());
            end
            w.coord = site;
            r = $urandom_range(99);
            if (r < 50) w.func = lsac_pkg::FUNC_ADD;
            else if (r < 75) w.func = lsac_pkg::FUNC_READ;
            else if (r < 95) w.func = lsac_pkg::FUNC_CLEAR;
            else w.func = FUNC_SPARE;
            if ($urandom_range(99) < 12) begin
                case ($urandom_range(3))
                    0: w.diff = 16'h8000;
                    1: w.diff = 16'h7FFF;
                    2: w.diff = 16'hFFFF;
                    default: w.diff = 16'h0001;
                endcase
            end else begin
                w.diff = lsac_pkg::DATA_W'($urandom_range(65535));
            end
            pending_words.insert(pending_words.size(), w);
            words_queued++;
        end
    endtask

    // Wait until every queued word is taken and answered, then let the
    // pipeline settle.
    task automatic wait_drained();
        while (words_accepted != words_queued || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic cfg_write(input logic [lsac_pkg::REG_IDX_W-1:0] idx,
                             input logic [lsac_pkg::PDATA_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lsac_pkg::REG_NUM_DIMS: cfg_num_dims = value[lsac_pkg::NDIM_W-1:0];
            lsac_pkg::REG_LEN_DIM0, lsac_pkg::REG_LEN_DIM1,
            lsac_pkg::REG_LEN_DIM2, lsac_pkg::REG_LEN_DIM3:
                cfg_len[idx - lsac_pkg::REG_LEN_DIM0] = value[lsac_pkg::LEN_W-1:0];
            lsac_pkg::REG_OPEN_EDGES: cfg_open = value[2*lsac_pkg::NUM_COORDS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int dims, input int l0, input int l1, input int l2,
                                input int l3, input int edges);
        cfg_write(lsac_pkg::REG_NUM_DIMS, lsac_pkg::PDATA_W'(dims));
        cfg_write(lsac_pkg::REG_LEN_DIM0, lsac_pkg::PDATA_W'(l0));
        cfg_write(lsac_pkg::REG_LEN_DIM1, lsac_pkg::PDATA_W'(l1));
        cfg_write(lsac_pkg::REG_LEN_DIM2, lsac_pkg::PDATA_W'(l2));
        cfg_write(lsac_pkg::REG_LEN_DIM3, lsac_pkg::PDATA_W'(l3));
        cfg_write(lsac_pkg::REG_OPEN_EDGES, lsac_pkg::PDATA_W'(edges));
    endtask

    // One random phase under a fixed geometry and idling mix. A hold-off
    // stalls the result side while words keep coming; a pause lets the
    // block drain halfway through.
    task automatic run_phase(input int dims, input int l0, input int l1, input int l2,
                             input int l3, input int edges, input int tx_pct,
                             input int rx_pct, input bit hold, input bit pause);
        wait_drained();
        set_geometry(dims, l0, l1, l2, l3, edges);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        recent_sites.delete();
        if (hold) hold_requests++;
        queue_random_words(PHASE_WORDS / 2);
        if (pause) wait_drained();
        queue_random_words(PHASE_WORDS - PHASE_WORDS / 2);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: two dimensions of length one, all edges closed.
        queue_word(lsac_pkg::FUNC_READ, 0, 0, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_ADD, 0, 0, 0, 0, 32767);
        queue_word(lsac_pkg::FUNC_ADD, 0, 0, 0, 0, 1);
        queue_word(lsac_pkg::FUNC_READ, 1, 0, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0);
        wait_drained();

        // 5 x 4 lattice, lower edge of dim 0 and upper edge of dim 1 open.
        set_geometry(2, 5, 4, 1, 1, 8'h09);
        queue_word(lsac_pkg::FUNC_READ, 2, 1, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_ADD, 4, 1, 0, 0, -32768);
        queue_word(lsac_pkg::FUNC_ADD, 4, 1, 0, 0, -1);
        queue_word(lsac_pkg::FUNC_ADD, 0, 3, 0, 0, 5);
        queue_word(lsac_pkg::FUNC_CLEAR, 4, 1, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_READ, 4, 1, 0, 0, 0);
        queue_word(FUNC_SPARE, 0, 3, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_READ, -1, 0, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_READ, 5, 0, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_ADD, 0, -32768, 0, 0, 9);
        queue_word(lsac_pkg::FUNC_CLEAR, 32767, 0, 0, 0, 0);
        queue_word(lsac_pkg::FUNC_ADD, 2, 2, -32768, 32767, -32768);
        queue_word(lsac_pkg::FUNC_ADD, 2, 2, 32767, -32768, -32768);
        queue_word(lsac_pkg::FUNC_ADD, 4, 3, -1, -1, 12345);
        queue_word(lsac_pkg::FUNC_CLEAR, 2, 2, 0, 0, 0);

        // Random phases: first the sender idles lightly and the receiver
        // heavily, then the reverse, then neither idles.
        run_phase(2, 64, 64, 1, 1, 8'h00, 11, 65, 1'b0, 1'b0);
        run_phase(1, 4096, 1, 1, 1, 8'h03, 11, 65, 1'b1, 1'b0);
        run_phase(3, 16, 16, 16, 1, 8'hA5, 11, 65, 1'b0, 1'b1);
        run_phase(4, 8, 8, 8, 8, 8'hFF, 65, 11, 1'b0, 1'b0);
        run_phase(4, 3, 5, 7, 11, 8'h5A, 65, 11, 1'b0, 1'b0);
        run_phase(0, 8191, 3, 0, 9, 8'h01, 65, 11, 1'b0, 1'b0);
        run_phase(7, 2, 1, 4096, 2, 8'hC3, 0, 0, 1'b1, 1'b0);
        run_phase(2, 100, 50, 1, 1, 8'h30, 0, 0, 1'b0, 1'b1);
        run_phase(3, 1, 0, 5, 5, 8'h0F, 0, 0, 1'b0, 1'b0);
        run_phase(4, 1, 1, 1, 1, 8'hAA, 0, 0, 1'b0, 1'b0);

        wait_drained();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS lattice_site_access_with_boundary_class");
        end else begin
            $display("FAIL lattice_site_access_with_boundary_class");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("FAIL lattice_site_access_with_boundary_class");
        $finish;
    end

endmodule

// ===== lattice_site_access_with_boundary_class.f =====
design/lsac_pkg.sv
design/lsac_queue.sv
design/lsac_front.sv
design/lsac_back.sv
design/lattice_site_access_with_boundary_class.sv
tb/tb.sv
